/* sv/lcst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Li Chao segment tree package
// Shared widths, stream layout, and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package lcst_pkg;

    localparam int DOMAIN_BITS_DEF = 10;

    localparam int SLOPE_W   = 32;
    localparam int ICPT_W    = 48;
    localparam int COORD_W   = 10;
    localparam int OUT_W     = 49;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 56;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        EV_NEW_L,
        EV_NEW_M,
        EV_OLD_L,
        EV_OLD_M,
        EV_QUERY
    } ev_sel_t;

    typedef struct packed {
        logic    clr_wr;
        logic    latch;
        logic    init;
        logic    dec_step;
        logic    rd;
        logic    new_wr;
        logic    ev_mul;
        logic    ev_add;
        ev_sel_t ev_sel;
        logic    pd_upd;
        logic    q_cmp;
        logic    q_step;
        logic    out_load;
    } lcst_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic ins_empty;
        logic x_oob;
        logic dec_done;
        logic dec_push;
        logic node_valid;
        logic leaf;
        logic out_busy;
    } lcst_status_t;

endpackage

/* sv/lcst_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Li Chao segment tree datapath
// Node memory, segment decomposition, line evaluation and the output register.
// ----------------------------------------------------------------------------
module lcst_datapath #(
    parameter int DOMAIN_BITS = lcst_pkg::DOMAIN_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lcst_pkg::lcst_cmd_t               cmd,
    output lcst_pkg::lcst_status_t            status,
    input  logic [lcst_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lcst_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);
    import lcst_pkg::*;

    localparam int DB    = DOMAIN_BITS;
    localparam int IW    = DB + 1;
    localparam int NODES = 2 ** IW;
    localparam int CW    = DB + 2;
    localparam int FW    = (DB > COORD_W) ? DB : COORD_W;
    localparam int PW    = SLOPE_W + DB + 1;
    localparam int VW    = ((PW > ICPT_W) ? PW : ICPT_W) + 1;
    localparam int LW    = $clog2(DB + 1);
    localparam int EW    = SLOPE_W + ICPT_W + 1;
    localparam logic [FW-1:0] DMAX_F = FW'((2 ** DB) - 1);
    localparam logic signed [VW-1:0] SMAX = {{(VW-48){1'b0}}, {48{1'b1}}};
    localparam logic signed [VW-1:0] SMIN = {{(VW-48){1'b1}}, {48{1'b0}}};

    logic [EW-1:0] node_mem [NODES];

    logic signed [SLOPE_W-1:0] nk_reg, ck_reg, rdk_reg, ek;
    logic signed [ICPT_W-1:0]  nb_reg, cb_reg, rdb_reg, eb;
    logic                      rdv_reg;
    logic [COORD_W-1:0]        lo_reg, hi_reg, x_reg;
    logic                      action_reg;
    logic [CW-1:0]             dl_reg, dr_reg, dr_m1;
    logic [LW-1:0]             lev_reg, sh;
    logic [IW-1:0]             idx_reg, pidx, clr_reg;
    logic [DB-1:0]             l_reg, r_reg, m, x_d, ex, pl, pr, span_mask;
    logic [DB:0]               lr_sum;
    logic [IW+DB-1:0]          wide;
    logic [FW-1:0]             lo_f, hi_f, x_f, hi_c;
    logic signed [PW-1:0]      prod_reg, prod_next;
    logic signed [VW-1:0]      vnl_reg, vnm_reg, vol_reg, vom_reg, vq_reg, best_reg;
    logic signed [VW-1:0]      sum, sat;
    logic                      found_reg, lef, mid;
    logic                      ov_reg, ofound_reg;
    logic [OUT_W-1:0]          omin_reg;

    always_comb
    begin
        lo_f      = FW'(lo_reg);
        hi_f      = FW'(hi_reg);
        x_f       = FW'(x_reg);
        hi_c      = (hi_f > DMAX_F) ? DMAX_F : hi_f;
        x_d       = x_f[DB-1:0];
        lr_sum    = {1'b0, l_reg} + {1'b0, r_reg};
        m         = lr_sum[DB:1];
        dr_m1     = dr_reg - CW'(1);
        pidx      = dl_reg[0] ? dl_reg[IW-1:0] : dr_m1[IW-1:0];
        sh        = LW'(DB) - lev_reg;
        wide      = {{DB{1'b0}}, pidx} << sh;
        pl        = wide[DB-1:0];
        span_mask = {DB{1'b1}} >> lev_reg;
        pr        = pl | span_mask;
        lef       = vnl_reg < vol_reg;
        mid       = vnm_reg < vom_reg;
    end

    always_comb
    begin
        ek = ck_reg;
        eb = cb_reg;
        ex = l_reg;
        unique case (cmd.ev_sel)
            EV_NEW_L: ex = l_reg;
            EV_NEW_M: ex = m;
            EV_OLD_L:
            begin
                ek = rdk_reg;
                eb = rdb_reg;
            end
            EV_OLD_M:
            begin
                ek = rdk_reg;
                eb = rdb_reg;
                ex = m;
            end
            EV_QUERY:
            begin
                ek = rdk_reg;
                eb = rdb_reg;
                ex = x_d;
            end
            default: ex = l_reg;
        endcase
        prod_next = ek * $signed({1'b0, ex});
        sum       = VW'(prod_reg) + VW'(eb);
        if (best_reg > SMAX)
            sat = SMAX;
        else if (best_reg < SMIN)
            sat = SMIN;
        else
            sat = best_reg;
    end

    always_comb
    begin
        status.clr_last   = (clr_reg == {IW{1'b1}});
        status.is_query   = (action_reg == ACT_QUERY);
        status.ins_empty  = (lo_f > hi_c);
        status.x_oob      = (x_f > DMAX_F);
        status.dec_done   = (dl_reg >= dr_reg);
        status.dec_push   = dl_reg[0] | dr_reg[0];
        status.node_valid = rdv_reg;
        status.leaf       = (l_reg == r_reg);
        status.out_busy   = ov_reg & ~m_tready;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            node_mem[clr_reg] <= '0;
        else if (cmd.new_wr || (cmd.pd_upd && mid))
            node_mem[idx_reg] <= {1'b1, ck_reg, cb_reg};
        if (cmd.rd)
            {rdv_reg, rdk_reg, rdb_reg} <= node_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= s_tuser;
            nk_reg     <= s_tdata[31:0];
            nb_reg     <= s_tdata[79:32];
            lo_reg     <= s_tdata[89:80];
            hi_reg     <= s_tdata[99:90];
            x_reg      <= s_tdata[109:100];
        end
        if (cmd.init)
        begin
            dl_reg    <= {2'b01, lo_f[DB-1:0]};
            dr_reg    <= {2'b01, hi_c[DB-1:0]} + CW'(1);
            lev_reg   <= LW'(DB);
            idx_reg   <= IW'(1);
            l_reg     <= '0;
            r_reg     <= '1;
            best_reg  <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.dec_step)
        begin
            if (status.dec_push)
            begin
                idx_reg <= pidx;
                l_reg   <= pl;
                r_reg   <= pr;
                ck_reg  <= nk_reg;
                cb_reg  <= nb_reg;
                if (dl_reg[0])
                    dl_reg <= dl_reg + CW'(1);
                else
                    dr_reg <= dr_m1;
            end
            else
            begin
                dl_reg  <= dl_reg >> 1;
                dr_reg  <= dr_reg >> 1;
                lev_reg <= lev_reg - LW'(1);
            end
        end
        if (cmd.ev_mul)
            prod_reg <= prod_next;
        if (cmd.ev_add)
        begin
            case (cmd.ev_sel)
                EV_NEW_L: vnl_reg <= sum;
                EV_NEW_M: vnm_reg <= sum;
                EV_OLD_L: vol_reg <= sum;
                EV_OLD_M: vom_reg <= sum;
                default:  vq_reg  <= sum;
            endcase
        end
        if (cmd.pd_upd)
        begin
            if (mid)
            begin
                ck_reg <= rdk_reg;
                cb_reg <= rdb_reg;
            end
            if (lef != mid)
            begin
                idx_reg <= {idx_reg[IW-2:0], 1'b0};
                r_reg   <= m;
            end
            else
            begin
                idx_reg <= {idx_reg[IW-2:0], 1'b1};
                l_reg   <= m + DB'(1);
            end
        end
        if (cmd.q_cmp && (!found_reg || vq_reg < best_reg))
        begin
            best_reg  <= vq_reg;
            found_reg <= 1'b1;
        end
        if (cmd.q_step)
        begin
            if (x_d <= m)
            begin
                idx_reg <= {idx_reg[IW-2:0], 1'b0};
                r_reg   <= m;
            end
            else
            begin
                idx_reg <= {idx_reg[IW-2:0], 1'b1};
                l_reg   <= m + DB'(1);
            end
        end
        if (cmd.out_load)
        begin
            omin_reg   <= sat[OUT_W-1:0];
            ofound_reg <= found_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            clr_reg <= '0;
        end
        else
        begin
            if (cmd.out_load)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
            if (cmd.clr_wr)
                clr_reg <= clr_reg + IW'(1);
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, omin_reg};
    assign m_tuser  = ofound_reg;

endmodule

/* sv/lcst_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Li Chao segment tree controller
// Sequences memory clearing, segment inserts with push-down, and point queries.
// ----------------------------------------------------------------------------
module lcst_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lcst_pkg::lcst_status_t status,
    output lcst_pkg::lcst_cmd_t    cmd
);
    import lcst_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACT,
        ST_DEC,
        ST_PD_RD,
        ST_PD_CHK,
        ST_EV_MUL,
        ST_EV_ADD,
        ST_PD_UPD,
        ST_Q_RD,
        ST_Q_CHK,
        ST_Q_MUL,
        ST_Q_ADD,
        ST_Q_CMP,
        ST_Q_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] ev_cnt_reg, ev_cnt_next;

    always_comb
    begin
        cmd         = '0;
        cmd.ev_sel  = ev_sel_t'({1'b0, ev_cnt_reg});
        state_next  = state_reg;
        ev_cnt_next = ev_cnt_reg;
        s_tready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                cmd.init = 1'b1;
                if (status.is_query)
                    state_next = status.x_oob ? ST_Q_DONE : ST_Q_RD;
                else
                    state_next = status.ins_empty ? ST_IDLE : ST_DEC;
            end
            ST_DEC:
            begin
                if (status.dec_done)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.dec_step = 1'b1;
                    if (status.dec_push)
                        state_next = ST_PD_RD;
                end
            end
            ST_PD_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_PD_CHK;
            end
            ST_PD_CHK:
            begin
                if (!status.node_valid)
                begin
                    cmd.new_wr = 1'b1;
                    state_next = ST_DEC;
                end
                else
                begin
                    ev_cnt_next = '0;
                    state_next  = ST_EV_MUL;
                end
            end
            ST_EV_MUL:
            begin
                cmd.ev_mul = 1'b1;
                state_next = ST_EV_ADD;
            end
            ST_EV_ADD:
            begin
                cmd.ev_add = 1'b1;
                if (ev_cnt_reg == 2'd3)
                    state_next = ST_PD_UPD;
                else
                begin
                    ev_cnt_next = ev_cnt_reg + 2'd1;
                    state_next  = ST_EV_MUL;
                end
            end
            ST_PD_UPD:
            begin
                cmd.pd_upd = 1'b1;
                state_next = status.leaf ? ST_DEC : ST_PD_RD;
            end
            ST_Q_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_Q_CHK;
            end
            ST_Q_CHK:
            begin
                if (status.node_valid)
                    state_next = ST_Q_MUL;
                else if (status.leaf)
                    state_next = ST_Q_DONE;
                else
                begin
                    cmd.q_step = 1'b1;
                    state_next = ST_Q_RD;
                end
            end
            ST_Q_MUL:
            begin
                cmd.ev_mul = 1'b1;
                cmd.ev_sel = EV_QUERY;
                state_next = ST_Q_ADD;
            end
            ST_Q_ADD:
            begin
                cmd.ev_add = 1'b1;
                cmd.ev_sel = EV_QUERY;
                state_next = ST_Q_CMP;
            end
            ST_Q_CMP:
            begin
                cmd.q_cmp = 1'b1;
                if (status.leaf)
                    state_next = ST_Q_DONE;
                else
                begin
                    cmd.q_step = 1'b1;
                    state_next = ST_Q_RD;
                end
            end
            ST_Q_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ev_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ev_cnt_reg <= ev_cnt_next;
        end
    end

endmodule

/* sv/li_chao_segment_min_tree_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Li Chao segment tree core
// Stores line segments over a 2^DOMAIN_BITS point domain, answers point minima.
// ----------------------------------------------------------------------------
// One item at a time. A query walks the tree levels (DOMAIN_BITS+1 levels),
// paced by the registered node memory read and the shared multiplier. An
// insert visits up to 2*DOMAIN_BITS canonical nodes and may push a line down
// below each of them, level by level.
// After reset a clearing pass over all 2^(DOMAIN_BITS+1) node entries runs
// before the first item is accepted.
module li_chao_segment_min_tree_core #(
    parameter int DOMAIN_BITS = lcst_pkg::DOMAIN_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // slope[31:0], intercept[79:32], seg_lo[89:80], seg_hi[99:90], x_point[109:100]
    input  logic [lcst_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // min_value[48:0]
    output logic [lcst_pkg::M_TDATA_W-1:0] m_tdata,
    // found
    output logic                           m_tuser
);
    import lcst_pkg::*;

    lcst_cmd_t    cmd;
    lcst_status_t status;

    lcst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lcst_datapath #(
        .DOMAIN_BITS (DOMAIN_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* sv/lcst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Li Chao segment tree port checker
// Watches the stream ports of the core for result and handshake consistency.
// ----------------------------------------------------------------------------
module lcst_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lcst_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lcst_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import lcst_pkg::*;

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("result without a line carries a nonzero value");

    a_pad_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:OUT_W] == '0)
        else $error("padding bits of the result are not zero");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("a second item was taken while one is in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting input item changed");

endmodule

bind li_chao_segment_min_tree_core lcst_checker u_lcst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
